// File: rtl/core/dhoat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhoat_pkg: shared types and constants
// Field widths, codes and configuration indexes of the double hash table.
// ----------------------------------------------------------------------------
package dhoat_pkg;
	localparam int Capacity  = 1024;
	localparam int IdxW      = $clog2(Capacity);
	localparam int CntW      = IdxW + 1;
	localparam int KeyW      = 64;
	localparam int ValW      = 64;
	localparam int HashW     = 32;
	localparam int CfgW      = 11;
	localparam int CfgIdxW   = 2;
	localparam int InDataW   = 168;
	localparam int OutDataW  = 96;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT  = 3'd0,
		ST_MISS = 3'd1,
		ST_NEW  = 3'd2,
		ST_UPD  = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MARK_OCC   = 2'd0,
		MARK_EMPTY = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

	localparam logic [CfgIdxW-1:0] CFG_BUCKETS = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_USED    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MINB    = 2'd2;
endpackage

// File: rtl/core/dhoat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhoat_ram: generic single port ram
// One address per cycle, an optional write and a read of the old data, registered read data.
// ----------------------------------------------------------------------------
module dhoat_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// File: rtl/core/double_hash_open_address_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_open_address_table: key/value table with double hashing
// Lookup, insert and remove over a probed bucket memory with tombs.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                      | tuser
// s_axis  | in  | op, key_hash, search_key, new_value        | -
// m_axis  | out | status, slot_index, found_value, live, rsz | -
// cfg     | in  | wr_en, wr_index, wr_data                   | -
// both hash remainders come from one shared restoring divider, one bit a
// cycle; each probe passes S_RD and S_CHK on the bucket rams, and S_FIN,
// S_WR and S_OUT finish the word
// after reset a clearing pass marks all 1024 buckets empty with s_axis_tready
// low; the next word is taken while a result waits in the output register,
// and a finished word stalls in its last state until that is free
module double_hash_open_address_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// op[1:0], key_hash[33:2], search_key[97:34], new_value[161:98], zero pad
	input  logic [dhoat_pkg::InDataW-1:0] s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// status[2:0], slot_index[12:3], found_value[76:13], live_entries[87:77],
	// resize_wanted[88], zero pad
	output logic [dhoat_pkg::OutDataW-1:0] m_axis_tdata,
	input  logic                         wr_en,
	input  logic [dhoat_pkg::CfgIdxW-1:0] wr_index,
	input  logic [dhoat_pkg::CfgW-1:0]    wr_data
);
	import dhoat_pkg::*;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_DIV1  = 9'b000000100,
		S_DIV2  = 9'b000001000,
		S_RD    = 9'b000010000,
		S_CHK   = 9'b000100000,
		S_FIN   = 9'b001000000,
		S_WR    = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [CfgW-1:0]     bcnt_q, ulim_q, minb_q;
	logic [CntW-1:0]     live_q, used_q;
	logic [IdxW-1:0]     clr_q;
	op_t                 op_q;
	logic [HashW-1:0]    hash_q;
	logic [CntW-1:0]     rem_q, div_q;
	logic [5:0]          bit_q;
	logic [KeyW-1:0]     key_q;
	logic [ValW-1:0]     val_q;
	logic [CntW-1:0]     n_q;
	logic [IdxW-1:0]     home_q, cur_q, step_q, tomb_q, fin_q;
	logic                tomb_v_q, wrap_q, fin_occ_q;
	status_t             st_q;
	logic [IdxW-1:0]     slot_q;
	logic [ValW-1:0]     fv_q;
	logic                rsz_q, ov_q;
	logic [OutDataW-1:0] out_q;

	// mark / key / value rams
	logic             m_we, kv_we;
	logic [IdxW-1:0]  m_addr;
	logic [1:0]       m_wd, m_rd;
	logic [KeyW-1:0]  k_rd;
	logic [ValW-1:0]  v_rd;

	dhoat_ram #(.Width(2), .Depth(Capacity)) u_marks (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
	dhoat_ram #(.Width(KeyW), .Depth(Capacity)) u_keys (
		.clk(clk), .we(kv_we && state_q == S_WR && !fin_occ_q), .addr(m_addr),
		.wdata(key_q), .rdata(k_rd));
	dhoat_ram #(.Width(ValW), .Depth(Capacity)) u_vals (
		.clk(clk), .we(kv_we), .addr(m_addr), .wdata(val_q), .rdata(v_rd));

	// active n, saturated
	logic [CntW-1:0] n_act;
	always_comb begin
		n_act = bcnt_q;
		if (bcnt_q < CntW'(3)) n_act = CntW'(3);
		if (bcnt_q > CntW'(Capacity)) n_act = CntW'(Capacity);
	end

	// shared divider step
	logic [CntW:0] trial;
	logic [CntW-1:0] rem_nx;
	logic            q_bit;
	assign trial  = {rem_q, hash_q[HashW-1]};
	assign q_bit  = trial >= {1'b0, div_q};
	assign rem_nx = q_bit ? CntW'(trial - {1'b0, div_q}) : trial[CntW-1:0];

	// probe next
	logic [CntW:0] nxt_sum;
	logic [IdxW-1:0] nxt;
	assign nxt_sum = {2'b0, cur_q} + {2'b0, step_q};
	assign nxt = (nxt_sum >= {1'b0, n_q}) ? IdxW'(nxt_sum - {1'b0, n_q}) : IdxW'(nxt_sum);

	logic is_occ, is_empty, is_tomb, key_eq;
	assign is_empty = m_rd[0];
	assign is_tomb  = !m_rd[0] && m_rd[1];
	assign is_occ   = m_rd == MARK_OCC;
	assign key_eq   = k_rd == key_q;

	// counts after change
	logic [CntW-1:0] live_nx, used_nx;
	logic            small_nx, rsz_nx;
	always_comb begin
		live_nx = live_q;
		used_nx = used_q;
		if (op_q == OP_REMOVE) live_nx = live_q - 1'b1;
		else begin
			live_nx = live_q + 1'b1;
			// a new entry without a tomb lands in an empty bucket
			if (!tomb_v_q) used_nx = used_q + 1'b1;
		end
		small_nx = (n_q >> 2) > live_nx && n_q > CntW'(minb_q);
		if (op_q == OP_REMOVE)
			rsz_nx = small_nx || (used_q > CntW'(ulim_q) && n_q > CntW'(minb_q));
		else
			rsz_nx = small_nx || (used_nx > CntW'(ulim_q) &&
				{live_nx, 1'b0} >= {1'b0, CntW'(minb_q)});
	end

	always_comb begin
		m_we   = 1'b0;
		kv_we  = 1'b0;
		m_wd   = MARK_EMPTY;
		m_addr = cur_q;
		case (state_q)
			S_CLEAR: begin
				m_we = 1'b1; m_addr = clr_q;
			end
			S_WR: begin
				m_addr = fin_q;
				if (op_q == OP_REMOVE && st_q == ST_HIT) begin
					m_we = 1'b1; m_wd = MARK_TOMB;
				end else if (op_q == OP_INSERT && (st_q == ST_NEW || st_q == ST_UPD)) begin
					m_we = 1'b1; m_wd = MARK_OCC; kv_we = 1'b1;
				end
			end
			S_FIN: m_addr = fin_q;
			default: m_addr = cur_q;
		endcase
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			bcnt_q  <= CfgW'(53);
			ulim_q  <= CfgW'(39);
			minb_q  <= CfgW'(53);
			live_q  <= '0;
			used_q  <= '0;
			clr_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_BUCKETS: bcnt_q <= wr_data;
					CFG_USED:    ulim_q <= wr_data;
					CFG_MINB:    minb_q <= wr_data;
					default: ;
				endcase
			end
			if (state_q == S_OUT && (!ov_q || m_axis_tready)) ov_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: if (s_axis_tvalid && s_axis_tready) state_q <= S_DIV1;
				S_DIV1: if (bit_q == 6'd31) state_q <= S_DIV2;
				S_DIV2: if (bit_q == 6'd31) state_q <= S_RD;
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (is_empty || (is_occ && key_eq) || nxt == home_q)
						state_q <= S_FIN;
					else state_q <= S_RD;
				end
				S_FIN: state_q <= S_WR;
				S_WR: begin
					if (st_q == ST_NEW || st_q == ST_HIT && op_q == OP_REMOVE) begin
						live_q <= live_nx;
						used_q <= used_nx;
					end
					state_q <= S_OUT;
				end
				S_OUT: if (!ov_q || m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= op_t'(s_axis_tdata[1:0]);
				hash_q <= s_axis_tdata[33:2];
				key_q  <= s_axis_tdata[97:34];
				val_q  <= s_axis_tdata[161:98];
				n_q    <= n_act;
				div_q  <= n_act;
				rem_q  <= '0;
				bit_q  <= '0;
			end
			S_DIV1, S_DIV2: begin
				hash_q <= {hash_q[HashW-2:0], hash_q[HashW-1]};
				if (bit_q == 6'd31) begin
					bit_q <= '0;
					rem_q <= '0;
					if (state_q == S_DIV1) begin
						home_q   <= IdxW'(rem_nx);
						cur_q    <= IdxW'(rem_nx);
						div_q    <= n_q - 1'b1;
						tomb_v_q <= 1'b0;
						wrap_q   <= 1'b0;
					end else begin
						step_q <= IdxW'(rem_nx + 1'b1);
					end
				end else begin
					rem_q <= rem_nx;
					bit_q <= bit_q + 1'b1;
				end
			end
			S_CHK: begin
				if (is_empty || (is_occ && key_eq)) begin
					wrap_q <= 1'b0;
				end else begin
					if (is_tomb) begin
						tomb_q <= cur_q; tomb_v_q <= 1'b1;
					end
					if (nxt == home_q) wrap_q <= 1'b1;
					else cur_q <= nxt;
				end
				fin_occ_q <= is_occ && key_eq;
				fv_q <= v_rd;
			end
			S_FIN: begin
				rsz_q <= 1'b0;
				case (op_q)
					OP_LOOKUP, OP_REMOVE: begin
						fin_q <= cur_q;
						if (!wrap_q && fin_occ_q) begin
							st_q <= ST_HIT; slot_q <= cur_q;
						end else begin
							st_q <= ST_MISS; slot_q <= '0;
						end
					end
					OP_INSERT: begin
						if (!wrap_q && fin_occ_q) begin
							fin_q <= cur_q; st_q <= ST_UPD; slot_q <= cur_q;
						end else if (tomb_v_q) begin
							fin_q <= tomb_q; st_q <= ST_NEW; slot_q <= tomb_q;
						end else if (!wrap_q) begin
							fin_q <= cur_q; st_q <= ST_NEW; slot_q <= cur_q;
						end else begin
							st_q <= ST_FULL; slot_q <= '0;
						end
					end
					default: begin
						st_q <= ST_MISS; slot_q <= '0;
					end
				endcase
				if (!(op_q == OP_LOOKUP && !wrap_q && fin_occ_q)) fv_q <= '0;
			end
			S_WR: begin
				rsz_q <= (st_q == ST_NEW || st_q == ST_HIT && op_q == OP_REMOVE) ?
					rsz_nx : 1'b0;
			end
			S_OUT: begin
				if (!ov_q || m_axis_tready)
					out_q <= {7'b0, rsz_q, live_q, fv_q, slot_q, st_q};
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_live_cap: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CntW'(Capacity)) else $error("live count overflow");
	a_live_used: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= used_q) else $error("live above used");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |=> ov_q) else $error("result lost");
`endif
endmodule
